### rtl/pdt_pkg.sv
`timescale 1ns / 1ps
// Package for the pairwise distance table: field widths, request codes
// and the command record that travels from the front end to the back end.
// No dependencies.
package pdt_pkg;

	localparam int SLOT_W      = 3;
	localparam int COORD_W     = 15;
	localparam int TICK_W      = 32;
	localparam int DIST_W      = 16;
	localparam int SQ_W        = 2 * COORD_W;
	localparam int ROOT_W      = 32;

	localparam int NUM_SLOTS_DEF = 8;

	// Command queue between front and back; the depth is a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Request codes carried in req_type.
	localparam logic REQ_POS  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic               is_tick;
		logic [SLOT_W-1:0]  slot;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [TICK_W-1:0]  tick;
	} cmd_t;

endpackage

### rtl/pdt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
// Depends on pdt_pkg.
interface pdt_req_if import pdt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [SLOT_W-1:0]  slot;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic [TICK_W-1:0]  tick_number;

	modport source (output valid, req_type, slot, pos_x, pos_y, tick_number, input ready);
	modport sink   (input valid, req_type, slot, pos_x, pos_y, tick_number, output ready);
endinterface

interface pdt_res_if import pdt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] tick_id;
	logic [SLOT_W-1:0] first_slot;
	logic [SLOT_W-1:0] second_slot;
	logic [DIST_W-1:0] distance;
	logic              both_seen;
	logic              last_pair;

	modport source (output valid, tick_id, first_slot, second_slot, distance, both_seen,
		last_pair, input ready);
	modport sink   (input valid, tick_id, first_slot, second_slot, distance, both_seen,
		last_pair, output ready);
endinterface

### rtl/pdt_front.sv
`timescale 1ns / 1ps
// Front end: takes request transfers, drops position updates for slots that
// do not exist and holds one command for the queue. Depends on pdt_pkg, pdt_if.
module pdt_front import pdt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pdt_req_if.sink   req,
	output cmd_t      push_cmd,
	output logic      push_vld,
	input  logic      push_rdy
);

	logic vld_q;
	cmd_t cmd_q;
	logic req_take;
	logic keep;

	assign req.ready = !vld_q || push_rdy;
	assign req_take  = req.valid && req.ready;
	// A tick always goes on; an update only when its slot is in the table.
	assign keep      = (req.req_type == REQ_TICK) || (int'(req.slot) < NUM_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (req_take) begin
			vld_q <= keep;
		end else if (push_rdy) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q.is_tick <= (req.req_type == REQ_TICK);
			cmd_q.slot    <= req.slot;
			cmd_q.pos_x   <= req.pos_x;
			cmd_q.pos_y   <= req.pos_y;
			cmd_q.tick    <= req.tick_number;
		end
	end

	assign push_vld = vld_q;
	assign push_cmd = cmd_q;

endmodule

### rtl/pdt_queue.sv
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the back end.
// Depends on pdt_pkg.
module pdt_queue import pdt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_cmd,
	input  logic push_vld,
	output logic push_rdy,
	output cmd_t pop_cmd,
	output logic pop_vld,
	input  logic pop_rdy
);

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_rdy = (cnt_q != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign pop_vld  = (cnt_q != '0);
	assign pop_cmd  = mem_q[rd_ptr_q];
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop_vld && pop_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QUEUE_PTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QUEUE_PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/pdt_back.sv
`timescale 1ns / 1ps
// Back end: position table, pair walker, squares, bit-serial integer root
// and the result register. Depends on pdt_pkg, pdt_if.
module pdt_back import pdt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      pop_cmd,
	input  logic      pop_vld,
	output logic      pop_rdy,
	pdt_res_if.source res
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam logic [IDX_W-1:0] LAST_I = IDX_W'(NUM_SLOTS - 2);
	localparam logic [IDX_W-1:0] LAST_J = IDX_W'(NUM_SLOTS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_DIFF = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_ROOT = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	localparam logic [ROOT_W-1:0] BIT_FIRST = ROOT_W'(1) << (ROOT_W - 2);
	localparam logic [ROOT_W-1:0] BIT_LAST  = ROOT_W'(1);

	logic [2:0]           state_q;
	logic [IDX_W-1:0]     i_q;
	logic [IDX_W-1:0]     j_q;
	logic [NUM_SLOTS-1:0] seen_q;
	logic [TICK_W-1:0]    tick_q;

	logic [COORD_W-1:0]   x_mem [NUM_SLOTS];
	logic [COORD_W-1:0]   y_mem [NUM_SLOTS];
	logic [COORD_W-1:0]   xa_s1, xb_s1, ya_s1, yb_s1;
	logic [COORD_W-1:0]   dx_s2, dy_s2;
	logic [SQ_W-1:0]      sqx_s3, sqy_s3;
	logic [ROOT_W-1:0]    v_q, root_q, bit_q;

	logic                 out_vld_q;
	logic [TICK_W-1:0]    out_tick_q;
	logic [SLOT_W-1:0]    out_first_q;
	logic [SLOT_W-1:0]    out_second_q;
	logic [DIST_W-1:0]    out_dist_q;
	logic                 out_both_q;
	logic                 out_last_q;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	logic [ROOT_W-1:0]    trial;
	logic                 trial_fits;
	logic                 out_load;
	logic                 pair_both;
	logic                 pair_last;

	assign pop_rdy    = (state_q == ST_IDLE);
	assign wr_en      = pop_rdy && pop_vld && !pop_cmd.is_tick;
	assign wr_idx     = IDX_W'(pop_cmd.slot);
	assign trial      = root_q + bit_q;
	assign trial_fits = (v_q >= trial);
	assign out_load   = (state_q == ST_EMIT) && (!out_vld_q || res.ready);
	assign pair_both  = seen_q[i_q] && seen_q[j_q];
	assign pair_last  = (i_q == LAST_I) && (j_q == LAST_J);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			seen_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (wr_en) begin
						seen_q[wr_idx] <= 1'b1;
					end else if (pop_vld) begin
						i_q     <= '0;
						j_q     <= IDX_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ROOT;
				ST_ROOT: begin
					if (bit_q == BIT_LAST) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (pair_last) begin
							state_q <= ST_IDLE;
						end else if (j_q == LAST_J) begin
							i_q     <= i_q + IDX_W'(1);
							j_q     <= i_q + IDX_W'(1) + IDX_W'(1);
							state_q <= ST_READ;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Position table: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[wr_idx] <= pop_cmd.pos_x;
			y_mem[wr_idx] <= pop_cmd.pos_y;
		end
		xa_s1 <= x_mem[i_q];
		xb_s1 <= x_mem[j_q];
		ya_s1 <= y_mem[i_q];
		yb_s1 <= y_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (pop_rdy && pop_vld && pop_cmd.is_tick) begin
			tick_q <= pop_cmd.tick;
		end
		if (state_q == ST_DIFF) begin
			dx_s2 <= (xa_s1 >= xb_s1) ? (xa_s1 - xb_s1) : (xb_s1 - xa_s1);
			dy_s2 <= (ya_s1 >= yb_s1) ? (ya_s1 - yb_s1) : (yb_s1 - ya_s1);
		end
		if (state_q == ST_SQR) begin
			sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
			sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		end
		// Restoring square root, one result bit per cycle.
		if (state_q == ST_SUM) begin
			v_q    <= ROOT_W'(sqx_s3) + ROOT_W'(sqy_s3);
			root_q <= '0;
			bit_q  <= BIT_FIRST;
		end else if (state_q == ST_ROOT) begin
			if (trial_fits) begin
				v_q    <= v_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (out_load) begin
			out_tick_q   <= tick_q;
			out_first_q  <= SLOT_W'(i_q);
			out_second_q <= SLOT_W'(j_q);
			out_dist_q   <= pair_both ? DIST_W'(root_q) : '0;
			out_both_q   <= pair_both;
			out_last_q   <= pair_last;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.tick_id     = out_tick_q;
	assign res.first_slot  = out_first_q;
	assign res.second_slot = out_second_q;
	assign res.distance    = out_dist_q;
	assign res.both_seen   = out_both_q;
	assign res.last_pair   = out_last_q;

endmodule

### rtl/pairwise_distance_table_unit.sv
`timescale 1ns / 1ps
// Pairwise distance table. A position update writes x and y of one slot and
// marks it seen; it produces no result and leaves the back end idle. An
// update for a slot at or above NUM_SLOTS is dropped. A tick produces one
// result transfer for every slot pair i<j, i outer and j inner, carrying the
// tick number, both slot numbers (low three bits) and the floor of the exact
// Euclidean distance, or zero with both_seen low when either slot was never
// written; the final pair has last_pair set. A tick occupies the back end
// until the result of its final pair is loaded: each pair costs a table
// read, an absolute difference, two squares, a sum, the bit-serial square
// root and a load of the result register. Requests are taken into a front
// register and a two-entry command queue, so up to three requests are still
// taken while the back end works on a tick or while a result waits to be
// taken; after that the request side stalls until the back end frees a queue
// entry.
// Depends on pdt_pkg, pdt_if, pdt_front, pdt_queue, pdt_back.
module pairwise_distance_table_unit import pdt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pdt_req_if.sink   req,
	pdt_res_if.source res
);

	cmd_t push_cmd;
	logic push_vld;
	logic push_rdy;
	cmd_t pop_cmd;
	logic pop_vld;
	logic pop_rdy;

	// Front end classifies requests and drops updates for missing slots.
	pdt_front #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.push_cmd (push_cmd),
		.push_vld (push_vld),
		.push_rdy (push_rdy)
	);

	// Commands keep their order, so a tick sees every update taken before it.
	pdt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cmd (push_cmd),
		.push_vld (push_vld),
		.push_rdy (push_rdy),
		.pop_cmd  (pop_cmd),
		.pop_vld  (pop_vld),
		.pop_rdy  (pop_rdy)
	);

	// Back end owns the table and walks the pairs of each tick.
	pdt_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop_cmd (pop_cmd),
		.pop_vld (pop_vld),
		.pop_rdy (pop_rdy),
		.res     (res)
	);

endmodule
